// ===== rtl/tftd_pkg.sv =====
package tftd_pkg;

    localparam int AccelW = 18;
    localparam int AngleW = 24;
    localparam int RollW = 17;
    localparam int PitchW = 16;
    localparam int MsW = 16;
    localparam int AlphaW = 17;
    localparam int LimitW = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 18;
    localparam int CordicStepsDefault = 16;
    localparam int CordicStepsMax = 24;
    localparam int CordicW = 48;
    localparam int ZW = 26;

    localparam logic [CfgIdxW-1:0] RegAccelBiasX = 3'd0;
    localparam logic [CfgIdxW-1:0] RegAccelBiasY = 3'd1;
    localparam logic [CfgIdxW-1:0] RegAccelBiasZ = 3'd2;
    localparam logic [CfgIdxW-1:0] RegGyroBiasX = 3'd3;
    localparam logic [CfgIdxW-1:0] RegGyroBiasY = 3'd4;
    localparam logic [CfgIdxW-1:0] RegBlendWeight = 3'd5;
    localparam logic [CfgIdxW-1:0] RegLimitFirst = 3'd6;
    localparam logic [CfgIdxW-1:0] RegLimitSecond = 3'd7;

    typedef struct packed {
        logic signed [AccelW-1:0] accel_x;
        logic signed [AccelW-1:0] accel_y;
        logic signed [AccelW-1:0] accel_z;
        logic signed [AccelW-1:0] rate_x;
        logic signed [AccelW-1:0] rate_y;
        logic [MsW-1:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic signed [RollW-1:0] roll_angle;
        logic signed [PitchW-1:0] pitch_angle;
        logic signed [AngleW-1:0] fused_first;
        logic signed [AngleW-1:0] fused_second;
        logic tipping;
    } t_out_item;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic [CfgDataW-1:0] data;
    } t_cfg_item;

    typedef struct packed {
        logic start;
        logic signed [CordicW-1:0] x;
        logic signed [CordicW-1:0] y;
    } t_cordic_req;

    typedef struct packed {
        logic done;
        logic signed [RollW+1:0] angle;
    } t_cordic_rsp;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0: v = 26'sd2949120;
            5'd1: v = 26'sd1740967;
            5'd2: v = 26'sd919879;
            5'd3: v = 26'sd466945;
            5'd4: v = 26'sd234379;
            5'd5: v = 26'sd117304;
            5'd6: v = 26'sd58666;
            5'd7: v = 26'sd29335;
            5'd8: v = 26'sd14668;
            5'd9: v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            5'd20: v = 26'sd4;
            5'd21: v = 26'sd2;
            5'd22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/tftd_if.sv =====
interface tftd_if #(
    parameter int W = 8
);
    logic valid;
    logic ready;
    logic [W-1:0] payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/tftd_cordic.sv =====
module tftd_cordic #(
    parameter int CORDIC_STEPS = tftd_pkg::CordicStepsDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tftd_pkg::t_cordic_req i_req,
    output tftd_pkg::t_cordic_rsp o_rsp
);
    import tftd_pkg::*;

    localparam int Steps = (CORDIC_STEPS < CordicStepsMax) ? CORDIC_STEPS : CordicStepsMax;

    logic signed [CordicW-1:0] r_x;
    logic signed [CordicW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic [4:0] r_i;
    logic r_busy;
    logic r_done;
    logic signed [RollW+1:0] r_angle;
    logic signed [ZW-1:0] z_round;

    assign z_round = r_z + ZW'(128);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_i <= '0;
                if (i_req.x == 0 && i_req.y == 0) begin
                    r_angle <= '0;
                    r_done <= 1'b1;
                end else if (i_req.x < 0) begin
                    r_busy <= 1'b1;
                    r_z <= (i_req.y >= 0) ? ZW'(11796480) : -ZW'(11796480);
                    r_x <= -i_req.x;
                    r_y <= -i_req.y;
                end else begin
                    r_busy <= 1'b1;
                    r_z <= '0;
                    r_x <= i_req.x;
                    r_y <= i_req.y;
                end
            end else if (r_busy) begin
                if (r_i == 5'(Steps)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_angle <= (RollW+2)'(z_round >>> 8);
                end else begin
                    if (r_y >= 0) begin
                        r_x <= r_x + (r_y >>> r_i);
                        r_y <= r_y - (r_x >>> r_i);
                        r_z <= r_z + atan_entry(r_i);
                    end else begin
                        r_x <= r_x - (r_y >>> r_i);
                        r_y <= r_y + (r_x >>> r_i);
                        r_z <= r_z - atan_entry(r_i);
                    end
                    r_i <= r_i + 5'd1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.angle = r_angle;

    busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("cordic done while busy");
    step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_i <= 5'(Steps)) else $error("cordic step overrun");
    start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_i == 0) else $error("cordic start");
endmodule

// ===== rtl/tftd_sqrt.sv =====
module tftd_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [57:0] i_value,
    output logic        o_done,
    output logic [28:0] o_root
);
    logic [57:0] r_rem;
    logic [57:0] r_root;
    logic [57:0] r_bit;
    logic r_busy;
    logic r_done;
    logic [57:0] trial;

    assign trial = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem <= i_value;
                r_root <= '0;
                r_bit <= 58'd1 << 56;
            end else if (r_busy) begin
                if (r_bit == 0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    if (r_rem >= trial) begin
                        r_rem <= r_rem - trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[28:0];

    done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("sqrt done without work");
    bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot0(r_bit)) else $error("sqrt bit");
    no_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("sqrt done busy");
endmodule

// ===== rtl/tilt_fusion_tipover_detector_top.sv =====
// Tilt fusion tip-over detector.
// An IMU item enters on i_in (accel x/y/z, rate x/y, elapsed_ms). The block
// removes the configured biases, computes roll and pitch with an iterative
// CORDIC vectoring unit, takes the pitch denominator from a bit-serial square
// root, and updates two complementary-filter angles with one shared
// multiplier. One result item leaves on o_out per input item.
// From acceptance to result, the two CORDIC runs and the square root
// dominate the work of an item.
// One item is processed at a time; i_in.ready is low while busy, so a new
// item is accepted only after the block has returned to idle.
// The result sits in an output register; the next item is accepted while
// that result still waits, and work stalls only if a new result is ready
// before the old one was taken.
// Configuration writes arrive on i_cfg (index, data) and take effect at once;
// they must be made only while the block is idle, which it does not enforce.
// Synchronous active-low reset restores register defaults (alpha 0.98,
// limits 45 degrees) and clears both fused angles.
module tilt_fusion_tipover_detector_top #(
    parameter int CORDIC_STEPS = tftd_pkg::CordicStepsDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tftd_if.sink   i_in,
    tftd_if.sink   i_cfg,
    tftd_if.source o_out
);
    import tftd_pkg::*;

    localparam logic [34:0] Div125Recip = 35'd1099511628;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ROLL, S_ROOT, S_PITCH, S_INC, S_DIV,
        S_B1, S_B2, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    t_in_item in_item;
    t_cfg_item cfg_item;
    t_out_item r_out;
    logic r_out_valid;

    logic signed [AccelW-1:0] r_bias [5];
    logic [AlphaW-1:0] r_alpha;
    logic [LimitW-1:0] r_lim1, r_lim2;
    logic signed [AngleW-1:0] r_f1, r_f2;

    logic signed [AccelW:0] r_ax, r_ay, r_az, r_gx, r_gy;
    logic [MsW-1:0] r_ms;
    logic [57:0] r_sq;
    logic r_ch;
    logic [1:0] r_sub;
    logic signed [RollW-1:0] r_roll;
    logic signed [PitchW-1:0] r_pitch;
    logic signed [35:0] r_prod;
    logic signed [35:0] r_inc;
    logic signed [50:0] r_num;

    logic signed [34:0] mul_a;
    logic signed [34:0] mul_b;
    logic signed [69:0] mul_p;
    t_cordic_req cq;
    t_cordic_rsp cr;
    logic sq_start, sq_done;
    logic [28:0] sq_root;
    logic signed [AngleW-1:0] old_f;
    logic signed [AccelW:0] g_sel;
    logic signed [RollW-1:0] acc_sel;
    logic [AlphaW-1:0] alpha_c;
    logic [35:0] mag;
    logic [35:0] div_x;
    logic signed [50:0] rnd;
    logic signed [AngleW-1:0] sat;
    logic [AngleW-1:0] a1, a2;
    logic signed [AngleW-1:0] n_f;

    assign in_item = t_in_item'(i_in.payload);
    assign cfg_item = t_cfg_item'(i_cfg.payload);
    assign i_cfg.ready = 1'b1;
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    assign alpha_c = (r_alpha > AlphaW'(65536)) ? AlphaW'(65536) : r_alpha;
    assign old_f = r_ch ? r_f2 : r_f1;
    assign g_sel = r_ch ? r_gy : r_gx;
    assign acc_sel = r_ch ? r_roll : RollW'(r_pitch);
    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                mul_a = r_sub[0] ? 35'(r_ay) : 35'(r_az);
                mul_b = mul_a;
            end
            S_INC: begin
                mul_a = 35'(g_sel);
                mul_b = 35'($signed({1'b0, r_ms}));
            end
            S_DIV: begin
                mul_a = 35'(div_x);
                mul_b = Div125Recip;
            end
            S_B1: begin
                mul_a = 35'($signed({1'b0, alpha_c}));
                mul_b = 35'(old_f) + 35'(r_inc);
            end
            S_B2: begin
                mul_a = 35'($signed(18'd65536 - 18'(alpha_c)));
                mul_b = 35'(acc_sel);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        cq.start = 1'b0;
        cq.x = '0;
        cq.y = '0;
        if (r_state == S_SQ && r_sub == 2'd2) begin
            cq.start = 1'b1;
            cq.x = CordicW'(r_ay) <<< 20;
            cq.y = CordicW'(r_az) <<< 20;
        end else if (r_state == S_ROOT && sq_done) begin
            cq.start = 1'b1;
            cq.x = CordicW'($signed({1'b0, sq_root})) <<< 10;
            cq.y = -(CordicW'(r_ax) <<< 20);
        end
    end
    assign sq_start = (r_state == S_ROLL) && cr.done;

    // Rounded-away quotient of |product| by 4000: a shift by 5, then a
    // reciprocal multiplication for the division by 125.
    assign mag = r_prod[35] ? 36'(-r_prod) : 36'(r_prod);
    assign div_x = (mag + 36'd2000) >> 5;
    assign rnd = r_num + 51'sd32768;
    assign sat = ((rnd >>> 16) > 51'sd8388607) ? 24'sd8388607 :
                 ((rnd >>> 16) < -51'sd8388608) ? -24'sd8388608 : AngleW'(rnd >>> 16);
    assign a1 = r_f1[AngleW-1] ? AngleW'(-r_f1) : AngleW'(r_f1);
    assign a2 = r_f2[AngleW-1] ? AngleW'(-r_f2) : AngleW'(r_f2);
    assign n_f = sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 5; k++) r_bias[k] <= '0;
            r_alpha <= AlphaW'(64225);
            r_lim1 <= LimitW'(11520);
            r_lim2 <= LimitW'(11520);
            r_f1 <= '0;
            r_f2 <= '0;
        end else begin
            if (o_out.valid && o_out.ready && r_state != S_OUT) r_out_valid <= 1'b0;
            if (i_cfg.valid) begin
                case (cfg_item.index)
                    RegAccelBiasX, RegAccelBiasY, RegAccelBiasZ, RegGyroBiasX,
                    RegGyroBiasY: r_bias[cfg_item.index] <= cfg_item.data;
                    RegBlendWeight: r_alpha <= cfg_item.data[AlphaW-1:0];
                    RegLimitFirst: r_lim1 <= cfg_item.data[LimitW-1:0];
                    RegLimitSecond: r_lim2 <= cfg_item.data[LimitW-1:0];
                    default: r_alpha <= r_alpha;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_ax <= (AccelW+1)'(in_item.accel_x) - (AccelW+1)'(r_bias[0]);
                        r_ay <= (AccelW+1)'(in_item.accel_y) - (AccelW+1)'(r_bias[1]);
                        r_az <= (AccelW+1)'(in_item.accel_z) - (AccelW+1)'(r_bias[2]);
                        r_gx <= (AccelW+1)'(in_item.rate_x) - (AccelW+1)'(r_bias[3]);
                        r_gy <= (AccelW+1)'(in_item.rate_y) - (AccelW+1)'(r_bias[4]);
                        r_ms <= in_item.elapsed_ms;
                        r_sub <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_sub == 2'd0) r_sq <= 58'(mul_p);
                    else if (r_sub == 2'd1) r_sq <= (r_sq + 58'(mul_p)) << 20;
                    r_sub <= r_sub + 2'd1;
                    if (r_sub == 2'd2) r_state <= S_ROLL;
                end
                S_ROLL: begin
                    if (cr.done) begin
                        r_roll <= (cr.angle > 19'sd46080) ? 17'sd46080 :
                                  (cr.angle < -19'sd46080) ? -17'sd46080 : RollW'(cr.angle);
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (sq_done) r_state <= S_PITCH;
                end
                S_PITCH: begin
                    if (cr.done) begin
                        r_pitch <= (cr.angle > 19'sd23040) ? 16'sd23040 :
                                   (cr.angle < -19'sd23040) ? -16'sd23040 : PitchW'(cr.angle);
                        r_ch <= 1'b0;
                        r_state <= S_INC;
                    end
                end
                S_INC: begin
                    r_prod <= 36'(mul_p);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_inc <= r_prod[35] ? -36'(mul_p[69:37]) : 36'(mul_p[69:37]);
                    r_state <= S_B1;
                end
                S_B1: begin
                    r_num <= 51'(mul_p);
                    r_state <= S_B2;
                end
                S_B2: begin
                    r_num <= r_num + 51'(mul_p);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_ch) begin
                        r_f2 <= n_f;
                        r_state <= S_OUT;
                    end else begin
                        r_f1 <= n_f;
                        r_ch <= 1'b1;
                        r_state <= S_INC;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out.roll_angle <= r_roll;
                        r_out.pitch_angle <= r_pitch;
                        r_out.fused_first <= r_f1;
                        r_out.fused_second <= r_f2;
                        r_out.tipping <= (a1 > AngleW'(r_lim1)) || (a2 > AngleW'(r_lim2));
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    tftd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk, .i_rst_n, .i_req(cq), .o_rsp(cr)
    );

    tftd_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_start(sq_start), .i_value(r_sq),
        .o_done(sq_done), .o_root(sq_root)
    );

    ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_state == S_SQ) else $error("accept lost");
    out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> o_out.valid) else $error("result dropped");
endmodule
